[hdl/lc3_subset_instruction_step_macros.svh]
// Assertion macros shared by the LC-3 subset step core.
`ifndef LC3_SUBSET_INSTRUCTION_STEP_MACROS_SVH
`define LC3_SUBSET_INSTRUCTION_STEP_MACROS_SVH

// Checked only outside reset.
`define LC3_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define LC3_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[hdl/lc3_pkg.sv]
// Types and constants of the LC-3 subset step core.
`timescale 1ns / 1ps

package lc3_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EXEC  = 2'd2
  } cmd_e;

  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LD   = 4'd2;
  localparam logic [3:0] OP_ST   = 4'd3;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_TRAP = 4'd15;

  localparam logic [2:0] CC_N = 3'b100;
  localparam logic [2:0] CC_Z = 3'b010;
  localparam logic [2:0] CC_P = 3'b001;

  localparam logic [7:0] HALT_VECT = 8'h25;
  localparam logic [2:0] LINK_REG  = 3'd7;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  addr;
    logic [15:0] wdata;
  } req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [15:0] pc_now;
    logic [2:0]  cond_codes;
    logic        halted;
  } res_t;

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    logic [2:0] f;
    if (v[15]) begin
      f = CC_N;
    end else if (v == 16'd0) begin
      f = CC_Z;
    end else begin
      f = CC_P;
    end
    return f;
  endfunction

endpackage

[hdl/lc3_chan_if.sv]
// Valid/ready channel carrying one request or one result.
`timescale 1ns / 1ps

interface lc3_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/lc3_subset_instruction_step.sv]
// Top level of the LC-3 subset step core.
// Every request (write word, read word, or execute one instruction) is handled
// combinationally: the instruction fetch, register reads, operand select, ALU, condition codes
// and the single memory write all happen in one pass over flop-based storage, and the
// result goes into a two-entry queue, so a new request is taken every cycle while the
// result side keeps up, and one more while a result waits. Results come back in the
// cycle after the request at the earliest. The word memory and its top eight words
// (R0 to R7) are flip-flops cleared in the reset cycle; addresses wrap at MEM_WORDS.
`timescale 1ns / 1ps
`include "lc3_subset_instruction_step_macros.svh"

module lc3_subset_instruction_step #(
  parameter int MEM_WORDS = 32
) (
  input logic       clk,
  input logic       rst,
  lc3_chan_if.sink   req,
  lc3_chan_if.source res
);
  import lc3_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam bit IS_POW2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);
  localparam int QSTEPS = 17 - AW;
  localparam logic [AW-1:0] REG_BASE = AW'(MEM_WORDS - 8);
  localparam logic [AW-1:0] R7_SLOT = AW'(MEM_WORDS - 1);

  function automatic logic [AW-1:0] wrap16(input logic [15:0] x);
    logic [15:0] r;
    r = x;
    if (!IS_POW2) begin
      for (int k = QSTEPS - 1; k >= 0; k--) begin
        if (32'(r) >= (MEM_WORDS << k)) begin
          r = r - 16'(MEM_WORDS << k);
        end
      end
    end
    return r[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] reg_slot(input logic [2:0] r);
    return REG_BASE + AW'(r);
  endfunction

  logic [15:0] store [MEM_WORDS];
  logic [15:0] pc;
  logic [2:0]  cc;

  logic [15:0] pc_next;
  logic [2:0]  cc_next;
  logic        we;
  logic [AW-1:0] waddr;
  logic [15:0] wword;

  logic          acc;
  logic          space;
  res_t          res_d;
  req_t          rq;
  logic [AW-1:0] fetch_slot;
  logic [AW-1:0] host_slot;
  logic [AW-1:0] tgt_slot;
  logic [AW-1:0] vect_slot;
  logic [15:0]   ir;
  logic [3:0]    op;
  logic [2:0]    dr;
  logic [2:0]    sr1;
  logic [15:0]   off9;
  logic [15:0]   src1;
  logic [15:0]   src2;
  logic [15:0]   pc_inc;
  logic [15:0]   tgt;
  logic [15:0]   val;

  assign rq        = req.data;
  assign req.ready = space;
  assign acc       = req.valid && space;

  assign fetch_slot = wrap16(pc);
  assign host_slot  = wrap16({11'd0, rq.addr});
  assign ir         = store[fetch_slot];
  assign op         = ir[15:12];
  assign dr         = ir[11:9];
  assign sr1        = ir[8:6];
  assign off9       = {{7{ir[8]}}, ir[8:0]};
  assign src1       = store[reg_slot(sr1)];
  assign src2       = ir[5] ? {{11{ir[4]}}, ir[4:0]} : store[reg_slot(ir[2:0])];
  assign pc_inc     = pc + 16'd1;
  assign tgt        = pc_inc + off9;
  assign tgt_slot   = wrap16(tgt);
  assign vect_slot  = wrap16({8'd0, ir[7:0]});

  always_comb begin
    pc_next         = pc;
    cc_next         = cc;
    we              = 1'b0;
    waddr           = host_slot;
    wword           = rq.wdata;
    val             = 16'd0;
    res_d.read_data = 16'd0;
    res_d.halted    = 1'b0;
    case (cmd_e'(rq.cmd))
      CMD_WRITE: begin
        we = 1'b1;
      end
      CMD_READ: begin
        res_d.read_data = store[host_slot];
      end
      CMD_EXEC: begin
        pc_next = pc_inc;
        case (op)
          OP_ADD, OP_AND, OP_NOT, OP_LD: begin
            case (op)
              OP_ADD:  val = src1 + src2;
              OP_AND:  val = src1 & src2;
              OP_NOT:  val = ~src1;
              default: val = store[tgt_slot];
            endcase
            we      = 1'b1;
            waddr   = reg_slot(dr);
            wword   = val;
            cc_next = flags_of(val);
          end
          OP_ST: begin
            we    = 1'b1;
            waddr = tgt_slot;
            wword = store[reg_slot(dr)];
          end
          OP_BR: begin
            if ((dr & cc) != 3'd0) begin
              pc_next = tgt;
            end
          end
          OP_JMP: begin
            pc_next = src1;
          end
          OP_TRAP: begin
            we           = 1'b1;
            waddr        = R7_SLOT;
            wword        = pc_inc;
            pc_next      = (vect_slot == R7_SLOT) ? pc_inc : store[vect_slot];
            res_d.halted = (ir[7:0] == HALT_VECT);
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    res_d.pc_now     = pc_next;
    res_d.cond_codes = cc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= 16'd0;
      cc <= 3'd0;
      for (int i = 0; i < MEM_WORDS; i++) begin
        store[i] <= 16'd0;
      end
    end else if (acc) begin
      pc <= pc_next;
      cc <= cc_next;
      if (we) begin
        store[waddr] <= wword;
      end
    end
  end

  lc3_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (acc),
    .push_data (res_d),
    .space     (space),
    .valid_out (res.valid),
    .data_out  (res.data),
    .pop       (res.ready)
  );

  `LC3_CHECK(a_cc_onehot0, $onehot0(cc), "condition codes not one-hot")
  `LC3_CHECK(a_pc_hold, (acc && rq.cmd != CMD_EXEC) |=> (pc == $past(pc)), "pc moved")
  `LC3_CHECK(a_trap_link, (acc && rq.cmd == CMD_EXEC && op == OP_TRAP) |=> (store[R7_SLOT] == 16'($past(pc) + 16'd1)), "bad R7 link")

endmodule

[hdl/lc3_outq.sv]
// Two-entry result queue between the core and the result channel.
`timescale 1ns / 1ps
`include "lc3_subset_instruction_step_macros.svh"

module lc3_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lc3_pkg::res_t push_data,
  output logic          space,
  output logic          valid_out,
  output lc3_pkg::res_t data_out,
  input  logic          pop
);
  import lc3_pkg::*;

  res_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign space     = (count != 2'd2);
  assign valid_out = (count != 2'd0);
  assign data_out  = slots[rd_ptr];
  assign do_pop    = pop && valid_out;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, do_pop};
    end
  end

  `LC3_CHECK_ALWAYS(a_reset_empty, rst |=> !valid_out, "queue not empty after reset")
  `LC3_CHECK(a_push_shows, push |=> valid_out, "pushed result not visible")
  `LC3_CHECK(a_no_overflow, push |-> space || do_pop, "push into full queue")

endmodule
